// ===== rtl/cc20_pkg.sv =====
package cc20_pkg;

	// ChaCha20 block constants ("expand 32-byte k").
	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	localparam int DOUBLE_ROUNDS_DEF  = 10;
	localparam int BYTES_PER_ITEM_DEF = 8;
	localparam int BLOCK_BYTES        = 64;
	localparam int BLOCK_BITS         = 8 * BLOCK_BYTES;
	localparam int AVAIL_W            = $clog2(BLOCK_BYTES + 1);

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY0     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY1     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY2     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY3     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_NONCE_LO = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_NONCE_HI = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_INIT_CTR = 3'd6;

	typedef logic [15:0][31:0] cc_state_t;

	typedef struct packed {
		logic        message_start;
		logic [63:0] plain_word;
		logic [3:0]  byte_count;
	} plain_item_t;

	typedef struct packed {
		logic [63:0] cipher_word;
		logic [3:0]  cipher_count;
	} cipher_item_t;

	// Handshake between the sequencer and the block engine.
	typedef struct packed {
		logic start;
	} core_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_status_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

endpackage

// ===== rtl/cc20_lane.sv =====
module cc20_lane (
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	input  logic [31:0] d,
	input  logic        second,
	output logic [31:0] a_o,
	output logic [31:0] b_o,
	output logic [31:0] c_o,
	output logic [31:0] d_o
);
	import cc20_pkg::*;

	logic [31:0] a_sum;
	logic [31:0] d_mix;
	logic [31:0] d_rot;
	logic [31:0] c_sum;
	logic [31:0] b_mix;
	logic [31:0] b_rot;

	// One half of a quarter round: rotations 16/12 in the first half, 8/7 in the second.
	always_comb begin
		a_sum = a + b;
		d_mix = d ^ a_sum;
		d_rot = second ? rotl32(d_mix, 8) : rotl32(d_mix, 16);
		c_sum = c + d_rot;
		b_mix = b ^ c_sum;
		b_rot = second ? rotl32(b_mix, 7) : rotl32(b_mix, 12);
	end

	assign a_o = a_sum;
	assign b_o = b_rot;
	assign c_o = c_sum;
	assign d_o = d_rot;

endmodule

// ===== rtl/cc20_core.sv =====
module cc20_core #(
	parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cc20_pkg::core_req_t              req,
	input  cc20_pkg::cc_state_t              init,
	output cc20_pkg::core_status_t           status,
	output logic [cc20_pkg::BLOCK_BITS-1:0]  keystream
);
	import cc20_pkg::*;

	localparam int STEPS  = 4 * DOUBLE_ROUNDS;
	localparam int STEP_W = $clog2(STEPS);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FEED} core_state_t;

	core_state_t       state_q;
	logic [STEP_W-1:0] step_q;
	cc_state_t         v_q;
	cc_state_t         v_next;
	cc_state_t         sum;
	logic              second;
	logic              diag;
	logic [3:0][31:0]  la;
	logic [3:0][31:0]  lb;
	logic [3:0][31:0]  lc;
	logic [3:0][31:0]  ld;
	logic [3:0][31:0]  la_o;
	logic [3:0][31:0]  lb_o;
	logic [3:0][31:0]  lc_o;
	logic [3:0][31:0]  ld_o;

	// Steps go column first half, column second half, diagonal first, diagonal second.
	assign second = step_q[0];
	assign diag   = step_q[1];

	// Route the working state to the four lanes: columns or diagonals.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			la[i] = v_q[i];
			if (diag) begin
				lb[i] = v_q[4 + ((i + 1) % 4)];
				lc[i] = v_q[8 + ((i + 2) % 4)];
				ld[i] = v_q[12 + ((i + 3) % 4)];
			end else begin
				lb[i] = v_q[4 + i];
				lc[i] = v_q[8 + i];
				ld[i] = v_q[12 + i];
			end
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_lane
		cc20_lane u_lane (
			.a      (la[g]),
			.b      (lb[g]),
			.c      (lc[g]),
			.d      (ld[g]),
			.second (second),
			.a_o    (la_o[g]),
			.b_o    (lb_o[g]),
			.c_o    (lc_o[g]),
			.d_o    (ld_o[g])
		);
	end

	// Scatter the lane results back to their state words.
	always_comb begin
		v_next = v_q;
		for (int i = 0; i < 4; i++) begin
			v_next[i] = la_o[i];
			if (diag) begin
				v_next[4 + ((i + 1) % 4)]  = lb_o[i];
				v_next[8 + ((i + 2) % 4)]  = lc_o[i];
				v_next[12 + ((i + 3) % 4)] = ld_o[i];
			end else begin
				v_next[4 + i]  = lb_o[i];
				v_next[8 + i]  = lc_o[i];
				v_next[12 + i] = ld_o[i];
			end
		end
	end

	// Merging stage: feed-forward addition of the input block.
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			sum[i] = v_q[i] + init[i];
		end
	end

	assign keystream   = sum;
	assign status.busy = (state_q != ST_IDLE);
	assign status.done = (state_q == ST_FEED);

	// Round sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						step_q  <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (step_q == STEP_W'(STEPS - 1)) begin
						state_q <= ST_FEED;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_FEED: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working state needs no reset; it is loaded at each start.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.start) begin
			v_q <= init;
		end else if (state_q == ST_RUN) begin
			v_q <= v_next;
		end
	end

endmodule

// ===== rtl/chacha20_stream_cipher_unit.sv =====
// ChaCha20 stream cipher (96-bit nonce, 32-bit block counter). Each plaintext transaction
// carries up to eight bytes in its low-order positions; each byte is XORed with the next
// keystream byte and the result comes back in the same positions, unused bytes zero. A set
// message_start flag reloads the block counter from initial_counter and drops any leftover
// keystream before the transaction's bytes are used. An item that finds keystream on hand
// is accepted, combined with the keystream and handed to the output register. An item that
// needs a fresh 64-byte block also waits while the four quarter-round lanes, which do half
// a quarter round per cycle, and the feed-forward merge produce it. The next item is
// accepted while a result still waits at the output. The user must write configuration
// only while the block is idle; the block itself does not enforce this. There is no
// clearing pass.
module chacha20_stream_cipher_unit #(
	parameter int DOUBLE_ROUNDS  = cc20_pkg::DOUBLE_ROUNDS_DEF,
	parameter int BYTES_PER_ITEM = cc20_pkg::BYTES_PER_ITEM_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               plain_valid,
	output logic                               plain_stall,
	input  cc20_pkg::plain_item_t              plain_item,
	output logic                               cipher_valid,
	input  logic                               cipher_stall,
	output cc20_pkg::cipher_item_t             cipher_item,
	input  logic                               cfg_we,
	input  logic [cc20_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [63:0]                        cfg_data
);
	import cc20_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_XOR, S_GEN, S_OUT} seq_state_t;

	seq_state_t             state_q;
	logic [3:0][63:0]       key_q;
	logic [63:0]            nonce_lo_q;
	logic [31:0]            nonce_hi_q;
	logic [31:0]            init_ctr_q;
	logic [31:0]            counter_q;
	logic [AVAIL_W-1:0]     avail_q;
	logic [3:0]             done_q;
	logic [3:0]             count_q;
	logic [63:0]            plain_q;
	logic [63:0]            acc_q;
	logic [BLOCK_BITS-1:0]  ks_q;
	logic                   cipher_valid_q;
	cipher_item_t           cipher_item_q;

	logic                   accept;
	logic                   out_load;
	logic [3:0]             count_sat;
	logic [3:0]             rem;
	logic [3:0]             take;
	logic                   need_block;
	logic [63:0]            ks_aligned;
	logic [63:0]            byte_mask;
	core_req_t              core_req;
	core_status_t           core_status;
	cc_state_t              init;
	logic [BLOCK_BITS-1:0]  core_ks;

	assign accept      = plain_valid && !plain_stall;
	assign plain_stall = (state_q != S_IDLE);

	// A finished item moves to the output register once that register is free.
	assign out_load = (state_q == S_OUT) && (!cipher_valid_q || !cipher_stall);

	// Byte counts above the lane width saturate.
	assign count_sat = (plain_item.byte_count > 4'(BYTES_PER_ITEM)) ?
		4'(BYTES_PER_ITEM) : plain_item.byte_count;

	// Bytes still to encrypt and how many the current block can serve.
	assign rem        = count_q - done_q;
	assign take       = (AVAIL_W'(rem) < avail_q) ? rem : avail_q[3:0];
	assign need_block = (rem != 4'd0) && (avail_q == '0);
	assign ks_aligned = ks_q[63:0] << {done_q, 3'b000};

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			byte_mask[8*j +: 8] = {8{(4'(j) >= done_q) && (4'(j) < done_q + take)}};
		end
	end

	// Block input: constants, key, counter and nonce.
	always_comb begin
		init[0] = SIGMA0;
		init[1] = SIGMA1;
		init[2] = SIGMA2;
		init[3] = SIGMA3;
		for (int i = 0; i < 4; i++) begin
			init[4 + 2*i] = key_q[i][31:0];
			init[5 + 2*i] = key_q[i][63:32];
		end
		init[12] = counter_q;
		init[13] = nonce_lo_q[31:0];
		init[14] = nonce_lo_q[63:32];
		init[15] = nonce_hi_q;
	end

	assign core_req.start = (state_q == S_XOR) && need_block;

	cc20_core #(
		.DOUBLE_ROUNDS (DOUBLE_ROUNDS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (core_req),
		.init      (init),
		.status    (core_status),
		.keystream (core_ks)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q      <= '0;
			nonce_lo_q <= '0;
			nonce_hi_q <= '0;
			init_ctr_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY0:     key_q[0]   <= cfg_data;
				REG_KEY1:     key_q[1]   <= cfg_data;
				REG_KEY2:     key_q[2]   <= cfg_data;
				REG_KEY3:     key_q[3]   <= cfg_data;
				REG_NONCE_LO: nonce_lo_q <= cfg_data;
				REG_NONCE_HI: nonce_hi_q <= cfg_data[31:0];
				REG_INIT_CTR: init_ctr_q <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	// Item sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			counter_q      <= '0;
			avail_q        <= '0;
			done_q         <= '0;
			cipher_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				cipher_valid_q <= 1'b1;
			end else if (cipher_valid_q && !cipher_stall) begin
				cipher_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						done_q  <= '0;
						state_q <= S_XOR;
						if (plain_item.message_start) begin
							counter_q <= init_ctr_q;
							avail_q   <= '0;
						end
					end
				end
				S_XOR: begin
					if (rem == 4'd0) begin
						state_q <= S_OUT;
					end else if (need_block) begin
						state_q <= S_GEN;
					end else begin
						done_q  <= done_q + take;
						avail_q <= avail_q - AVAIL_W'(take);
						if (take == rem) begin
							state_q <= S_OUT;
						end
					end
				end
				S_GEN: begin
					if (core_status.done) begin
						counter_q <= counter_q + 32'd1;
						avail_q   <= AVAIL_W'(BLOCK_BYTES);
						state_q   <= S_XOR;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: item, accumulated ciphertext, keystream window, result.
	always_ff @(posedge clk) begin
		if (accept) begin
			plain_q <= plain_item.plain_word;
			count_q <= count_sat;
			acc_q   <= '0;
		end
		if (state_q == S_XOR && !need_block && rem != 4'd0) begin
			acc_q <= acc_q | ((plain_q ^ ks_aligned) & byte_mask);
			ks_q  <= ks_q >> {take, 3'b000};
		end else if (state_q == S_GEN && core_status.done) begin
			ks_q <= core_ks;
		end
		if (out_load) begin
			cipher_item_q.cipher_word  <= acc_q;
			cipher_item_q.cipher_count <= count_q;
		end
	end

	assign cipher_valid = cipher_valid_q;
	assign cipher_item  = cipher_item_q;

endmodule

// ===== rtl/cc20_checker.sv =====
module cc20_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          plain_valid,
	input logic                          plain_stall,
	input logic                          cipher_valid,
	input logic                          cipher_stall,
	input cc20_pkg::cipher_item_t        cipher_item
);
	import cc20_pkg::*;

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cipher_valid && cipher_stall |=> cipher_valid && $stable(cipher_item))
		else $error("stalled cipher transaction changed");

	// A result never reports more bytes than one lane carries.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cipher_valid |-> cipher_item.cipher_count <= 4'd8)
		else $error("cipher_count out of range");

	// Bytes above the reported count are zero.
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cipher_valid |->
			(cipher_item.cipher_word >> {cipher_item.cipher_count, 3'b000}) == 64'd0)
		else $error("unused cipher bytes not zero");

	// The unit works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		plain_valid && !plain_stall |=> plain_stall)
		else $error("second item accepted while busy");

endmodule

bind chacha20_stream_cipher_unit cc20_checker u_cc20_checker (.*);

// ===== tb/testbench.sv =====
module testbench;
	import cc20_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
	localparam int STUCK_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int REPORT_LIMIT = 10;
	localparam int ITEMS_PER_PHASE = 280;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic plain_valid = 1'b0;
	logic plain_stall;
	plain_item_t plain_item = '0;
	logic cipher_valid;
	logic cipher_stall = 1'b0;
	cipher_item_t cipher_item;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	// Predictor copy of the configuration and keystream state.
	logic [63:0] key_w [4];
	logic [63:0] nonce_lo;
	logic [31:0] nonce_hi;
	logic [31:0] ctr_init;
	logic [31:0] ctr_now;
	logic [511:0] ks_buf;
	int ks_offset;

	plain_item_t plain_pending[$];
	cipher_item_t cipher_expected[$];

	int n_queued = 0;
	int n_plain_acc = 0;
	int n_cipher = 0;
	int error_count = 0;
	int block_count = 0;
	int wrap_count = 0;
	int setting_count = 0;
	bit plain_fire = 1'b0;
	int send_pct = 0;
	int recv_pct = 0;
	bit hold_request = 1'b0;

	chacha20_stream_cipher_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.plain_valid(plain_valid),
		.plain_stall(plain_stall),
		.plain_item(plain_item),
		.cipher_valid(cipher_valid),
		.cipher_stall(cipher_stall),
		.cipher_item(cipher_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Free-running clock, period 10.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic cc_state_t quarter_round(input cc_state_t s, input int a, input int b,
			input int c, input int d);
		s[a] = s[a] + s[b]; s[d] = rol32(s[d] ^ s[a], 16);
		s[c] = s[c] + s[d]; s[b] = rol32(s[b] ^ s[c], 12);
		s[a] = s[a] + s[b]; s[d] = rol32(s[d] ^ s[a], 8);
		s[c] = s[c] + s[d]; s[b] = rol32(s[b] ^ s[c], 7);
		return s;
	endfunction

	// One 64-byte keystream block; keystream byte k sits in bits 8k+7..8k.
	function automatic logic [511:0] keystream_for(input logic [31:0] ctr);
		cc_state_t init_s;
		cc_state_t work;
		logic [511:0] ks;
		init_s[0] = SIGMA0;
		init_s[1] = SIGMA1;
		init_s[2] = SIGMA2;
		init_s[3] = SIGMA3;
		for (int i = 0; i < 4; i++) begin
			init_s[4 + 2 * i] = key_w[i][31:0];
			init_s[5 + 2 * i] = key_w[i][63:32];
		end
		init_s[12] = ctr;
		init_s[13] = nonce_lo[31:0];
		init_s[14] = nonce_lo[63:32];
		init_s[15] = nonce_hi;
		work = init_s;
		for (int r = 0; r < DOUBLE_ROUNDS_DEF; r++) begin
			work = quarter_round(work, 0, 4, 8, 12);
			work = quarter_round(work, 1, 5, 9, 13);
			work = quarter_round(work, 2, 6, 10, 14);
			work = quarter_round(work, 3, 7, 11, 15);
			work = quarter_round(work, 0, 5, 10, 15);
			work = quarter_round(work, 1, 6, 11, 12);
			work = quarter_round(work, 2, 7, 8, 13);
			work = quarter_round(work, 3, 4, 9, 14);
		end
		for (int w = 0; w < 16; w++)
			ks[32 * w +: 32] = work[w] + init_s[w];
		return ks;
	endfunction

	// Expected ciphertext for one accepted plaintext transaction; advances the keystream.
	function automatic cipher_item_t encrypt_item(input plain_item_t it);
		cipher_item_t res;
		int n;
		if (it.message_start) begin
			ctr_now = ctr_init;
			ks_offset = BLOCK_BYTES;
		end
		n = it.byte_count;
		if (n > BYTES_PER_ITEM_DEF)
			n = BYTES_PER_ITEM_DEF;
		res.cipher_word = '0;
		for (int j = 0; j < n; j++) begin
			if (ks_offset >= BLOCK_BYTES) begin
				ks_buf = keystream_for(ctr_now);
				if (ctr_now == 32'hFFFF_FFFF)
					wrap_count++;
				ctr_now = ctr_now + 32'd1;
				ks_offset = 0;
				block_count++;
			end
			res.cipher_word[8 * j +: 8] = it.plain_word[8 * j +: 8] ^ ks_buf[8 * ks_offset +: 8];
			ks_offset++;
		end
		res.cipher_count = n[3:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (error_count < REPORT_LIMIT)
			$display("%0s mismatch at result %0d: expected %h, got %h", what, n_cipher, want, got);
		error_count++;
	endtask

	// Monitor: predicts on each plaintext transaction and checks each ciphertext transaction.
	always @(posedge clk) begin : monitor
		cipher_item_t want;
		plain_fire = arst_n && plain_valid && !plain_stall;
		if (plain_fire) begin
			cipher_expected.push_back(encrypt_item(plain_item));
			n_plain_acc++;
		end
		if (arst_n && cipher_valid && !cipher_stall) begin
			n_cipher++;
			if (cipher_expected.size() == 0) begin
				report_mismatch("unexpected result", 64'd0, cipher_item.cipher_word);
			end else begin
				want = cipher_expected.pop_front();
				if (cipher_item.cipher_word !== want.cipher_word)
					report_mismatch("cipher_word", want.cipher_word, cipher_item.cipher_word);
				if (cipher_item.cipher_count !== want.cipher_count)
					report_mismatch("cipher_count", 64'(want.cipher_count),
						64'(cipher_item.cipher_count));
			end
		end
	end

	// Driver: offers the next pending transaction once the current one is taken.
	always @(negedge clk) begin
		if (!plain_valid || plain_fire) begin
			if (plain_pending.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
				plain_item <= plain_pending.pop_front();
				plain_valid <= 1'b1;
			end else begin
				plain_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off when requested.
	always @(negedge clk) begin : receiver
		static int hold_left = 0;
		static bit hold_started = 1'b0;
		if (hold_request && !hold_started) begin
			hold_started = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			cipher_stall <= 1'b1;
		end else begin
			cipher_stall <= ($urandom_range(0, 99) < recv_pct);
		end
	end

	// Watchdog: ends the run when outstanding work makes no progress.
	initial begin : watchdog
		int stuck;
		int last_seen;
		stuck = 0;
		last_seen = 0;
		while (stuck < STUCK_LIMIT) begin
			@(negedge clk);
			if (n_plain_acc + n_cipher != last_seen ||
					(n_queued == n_plain_acc && cipher_expected.size() == 0))
				stuck = 0;
			else
				stuck++;
			last_seen = n_plain_acc + n_cipher;
		end
		$display("Watchdog: no transaction for %0d cycles", STUCK_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_KEY0: key_w[0] = val;
			REG_KEY1: key_w[1] = val;
			REG_KEY2: key_w[2] = val;
			REG_KEY3: key_w[3] = val;
			REG_NONCE_LO: nonce_lo = val;
			REG_NONCE_HI: nonce_hi = val[31:0];
			REG_INIT_CTR: ctr_init = val[31:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [63:0] k0, input logic [63:0] k1,
			input logic [63:0] k2, input logic [63:0] k3, input logic [63:0] nlo,
			input logic [63:0] nhi, input logic [63:0] ctr);
		write_reg(REG_KEY0, k0);
		write_reg(REG_KEY1, k1);
		write_reg(REG_KEY2, k2);
		write_reg(REG_KEY3, k3);
		write_reg(REG_NONCE_LO, nlo);
		write_reg(REG_NONCE_HI, nhi);
		write_reg(REG_INIT_CTR, ctr);
		setting_count++;
	endtask

	task automatic queue_item(input bit start, input logic [63:0] word, input logic [3:0] cnt);
		plain_item_t it;
		it.message_start = start;
		it.plain_word = word;
		it.byte_count = cnt;
		plain_pending.push_back(it);
		n_queued++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly well-formed messages with random content; some lack a start or restart midway.
	task automatic queue_messages(input int total);
		int left;
		int len;
		int r;
		bit st;
		logic [3:0] cnt;
		left = total;
		while (left > 0) begin
			len = $urandom_range(1, 24);
			if (len > left)
				len = left;
			for (int k = 0; k < len; k++) begin
				st = (k == 0 && $urandom_range(0, 99) >= 5) || ($urandom_range(0, 99) < 3);
				r = $urandom_range(0, 99);
				if (r < 6)
					cnt = 4'd0;
				else if (r < 12)
					cnt = 4'($urandom_range(9, 15));
				else
					cnt = 4'($urandom_range(1, 8));
				queue_item(st, rand64(), cnt);
			end
			left -= len;
		end
	endtask

	// Wait until every queued transaction has been answered, then let the block settle.
	task automatic drain();
		while (n_plain_acc != n_queued || cipher_expected.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin : stimulus
		logic [31:0] ctr;
		for (int i = 0; i < 4; i++)
			key_w[i] = '0;
		nonce_lo = '0;
		nonce_hi = '0;
		ctr_init = '0;
		ctr_now = '0;
		ks_buf = '0;
		ks_offset = BLOCK_BYTES;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed run at reset settings: zero and saturated counts, block crossing, restart.
		queue_item(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
		queue_item(1'b0, 64'h0, 4'd8);
		queue_item(1'b0, rand64(), 4'd0);
		queue_item(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
		queue_item(1'b0, 64'h0123_4567_89AB_CDEF, 4'd9);
		queue_item(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1);
		for (int i = 0; i < 4; i++)
			queue_item(1'b0, rand64(), 4'd8);
		queue_item(1'b0, rand64(), 4'd7);
		queue_item(1'b1, rand64(), 4'd4);
		queue_item(1'b0, rand64(), 4'd8);
		drain();

		// All-ones settings with the counter at its top value, so the second block wraps.
		load_settings('1, '1, '1, '1, '1, 64'hFFFF_FFFF, 64'hFFFF_FFFF);
		write_reg(REG_UNUSED, 64'h5A5A_5A5A_5A5A_5A5A);
		queue_item(1'b1, rand64(), 4'd8);
		for (int i = 0; i < 8; i++)
			queue_item(1'b0, rand64(), 4'd8);
		queue_item(1'b0, 64'h0, 4'd3);
		drain();

		// Random phases under different idling patterns.
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin send_pct = 0; recv_pct = 0; end
				1: begin send_pct = 56; recv_pct = 0; end
				2: begin send_pct = 0; recv_pct = 56; end
				3: begin send_pct = 12; recv_pct = 12; end
				default: begin send_pct = 0; recv_pct = 0; end
			endcase
			if (p == 0) begin
				// Key 00..1f and the nonce of the published block example.
				load_settings(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908,
					64'h1716_1514_1312_1110, 64'h1F1E_1D1C_1B1A_1918,
					64'h4A00_0000_0900_0000, 64'h0, 64'h1);
			end else begin
				ctr = (p == 3) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 3)) : $urandom;
				load_settings(rand64(), rand64(), rand64(), rand64(), rand64(),
					64'($urandom), 64'(ctr));
			end
			if (p == 2)
				write_reg(REG_UNUSED, rand64());
			queue_messages(ITEMS_PER_PHASE);
			if (p == 4)
				hold_request = 1'b1;
			drain();
		end

		// Tail: anything arriving now has no expectation and is flagged by the monitor.
		repeat (60) @(negedge clk);
		if (cipher_expected.size() != 0) begin
			$display("%0d expected results never arrived", cipher_expected.size());
			error_count++;
		end
		$display("Ran %0d plaintext transactions and checked %0d ciphertext results", n_plain_acc,
			n_cipher);
		$display("over %0d key settings: %0d keystream blocks, %0d counter wraps, %0d errors",
			setting_count, block_count, wrap_count, error_count);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
